@@ hdl/vertex_transform_project_raster_top_defines.svh @@
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Shared concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PROJECT_RASTER_TOP_DEFINES_SVH
`define VERTEX_TRANSFORM_PROJECT_RASTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define VTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/vtp_pkg.sv @@
// ----------------------------------------------------------------------------
// vtp_pkg
// Constants shared by the vertex transform and projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package vtp_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Configuration register indexes (byte address / 8).
  localparam logic [2:0] REG_ROT_X   = 3'd0;
  localparam logic [2:0] REG_ROT_Y   = 3'd1;
  localparam logic [2:0] REG_ROT_Z   = 3'd2;
  localparam logic [2:0] REG_TRANS   = 3'd3;
  localparam logic [2:0] REG_FOCAL   = 3'd4;
  localparam logic [2:0] REG_RES_X   = 3'd5;
  localparam logic [2:0] REG_RES_Y   = 3'd6;

  // Reset values: identity rotation, no translation, unit focal depth, VGA.
  localparam logic [47:0] ROT_X_RST  = 48'd16384;
  localparam logic [47:0] ROT_Y_RST  = 48'd1073741824;
  localparam logic [47:0] ROT_Z_RST  = 48'd70368744177664;
  localparam logic [47:0] TRANS_RST  = 48'd0;
  localparam logic [15:0] FOCAL_RST  = 16'd256;
  localparam logic [12:0] RES_X_RST  = 13'd640;
  localparam logic [12:0] RES_Y_RST  = 13'd480;

endpackage
`default_nettype wire

@@ hdl/vtp_div.sv @@
// ----------------------------------------------------------------------------
// vtp_div
// Pipelined restoring divider: one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
`default_nettype none
module vtp_div
  import vtp_pkg::*;
#(
  parameter int unsigned W     = COORD_WIDTH_DEF,
  parameter int unsigned NUM_W = COORD_WIDTH_DEF + 37,
  parameter int unsigned DEN_W = COORD_WIDTH_DEF + 14
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [DEN_W-1:0] den_i,
  output logic             [W-1:0]     q_o,
  output logic                         neg_o,
  output logic                         ovf_o
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W + W) ? NUM_W : DEN_W + W;

  logic [NUM_W-1:0] rem_q [W+1];
  logic [DEN_W-1:0] den_q [W+1];
  logic [W-1:0]     quo_q [W+1];
  logic             neg_q [W+1];
  logic             ovf_q [W+1];

  logic [NUM_W-1:0] mag;
  assign mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  // First stage: magnitude and sign, and a flag when the quotient reaches 2^W.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mag;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[NUM_W-1];
      ovf_q[0] <= CMP_W'(mag) >= (CMP_W'(den_i) << W);
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] trial;
    assign rem_ext = CMP_W'(rem_q[k-1]);
    assign trial   = CMP_W'(den_q[k-1]) << (W - k);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_ext >= trial) begin
          rem_q[k] <= NUM_W'(rem_ext - trial);
          quo_q[k] <= quo_q[k-1] | (W'(1) << (W - k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = quo_q[W];
  assign neg_o = neg_q[W];
  assign ovf_o = ovf_q[W];

endmodule
`default_nettype wire

@@ hdl/vertex_transform_project_raster_top.sv @@
// ----------------------------------------------------------------------------
// Vertex transform, perspective projection and raster mapping.
// Input items (s_axis) carry one world-space vertex; output items (m_axis)
// carry the pixel column and row, the view depth and, in tuser, a flag that
// marks a vertex at or behind the camera plane (pixels and depth then zero).
// The camera matrix, focal depth and raster size are set through the APB
// port at byte address 8*index; write them only while the pipeline is empty.
// The pipeline has five stages of matrix, projection and scaling
// arithmetic, one stage to take the magnitude, one stage per quotient bit
// of the two parallel dividers, and the output register. One item is taken
// every cycle unless the output stalls.
// The whole pipeline advances together: when the receiver holds tready low
// with a result waiting, s_axis_tready drops and every stage holds its item.
// Reset clears all valid bits and loads the configuration defaults: identity
// rotation, zero translation, focal depth 1.0 and a 640 by 480 raster.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_transform_project_raster_top_defines.svh"
module vertex_transform_project_raster_top
  import vtp_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // world_x, world_y, world_z
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // pixel_x, pixel_y, view_depth
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  // behind_camera
  output logic                                       m_axis_tuser,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [5:0]                            paddr,
  input  wire logic [63:0]                           pwdata,
  output logic [63:0]                                prdata,
  output logic                                       pready
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned TDW   = ((3*W+7)/8)*8;
  localparam int unsigned PW    = W + 16;
  localparam int unsigned AW    = W + 19;
  localparam int unsigned CAMW  = AW - 14;
  localparam int unsigned DW    = CAMW + 1;
  localparam int unsigned TW    = CAMW + 17;
  localparam int unsigned NXW   = TW + 1;
  localparam int unsigned NUMW  = NXW + 14;
  localparam int unsigned DENW  = W + 14;
  localparam int unsigned NST   = 5 + W + 1;
  localparam int unsigned SDN   = NST - 2;
  localparam logic [W-1:0] PIX_HI = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] PIX_LO = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic         behind;
    logic [W-1:0] depth;
  } side_t;

  // ---------------- configuration ----------------
  logic [47:0] rot_q [3];
  logic [47:0] trans_q;
  logic [15:0] focal_q;
  logic [12:0] res_x_q;
  logic [12:0] res_y_q;
  logic [2:0]  reg_idx;
  logic        cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= ROT_X_RST;
      rot_q[1] <= ROT_Y_RST;
      rot_q[2] <= ROT_Z_RST;
      trans_q  <= TRANS_RST;
      focal_q  <= FOCAL_RST;
      res_x_q  <= RES_X_RST;
      res_y_q  <= RES_Y_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_ROT_X: rot_q[0] <= pwdata[47:0];
        REG_ROT_Y: rot_q[1] <= pwdata[47:0];
        REG_ROT_Z: rot_q[2] <= pwdata[47:0];
        REG_TRANS: trans_q  <= pwdata[47:0];
        REG_FOCAL: focal_q  <= pwdata[15:0];
        REG_RES_X: res_x_q  <= pwdata[12:0];
        REG_RES_Y: res_y_q  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT_X: prdata = 64'(rot_q[0]);
      REG_ROT_Y: prdata = 64'(rot_q[1]);
      REG_ROT_Z: prdata = 64'(rot_q[2]);
      REG_TRANS: prdata = 64'(trans_q);
      REG_FOCAL: prdata = 64'(focal_q);
      REG_RES_X: prdata = 64'(res_x_q);
      REG_RES_Y: prdata = 64'(res_y_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic           en;
  logic [NST-1:0] vld_q;
  logic           out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NST-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[NST-1];
    end
  end

  // ---------------- stage 1: matrix products ----------------
  logic signed [W-1:0]  world [3];
  logic signed [PW-1:0] prod_q [3][3];

  for (genvar j = 0; j < 3; j++) begin : g_world
    assign world[j] = $signed(s_axis_tdata[j*W +: W]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[r][j] <= PW'($signed(rot_q[r][16*j +: 16]) * world[j]);
        end
      end
    end
  end

  // ---------------- stage 2: sum, translate, floor to Q13.8 ----------------
  logic signed [CAMW-1:0] cam_q [3];
  logic signed [AW-1:0]   acc [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(prod_q[r][0]) + AW'(prod_q[r][1]) + AW'(prod_q[r][2])
             + (AW'($signed(trans_q[16*r +: 16])) <<< 14);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cam_q[r] <= acc[r][AW-1:14];
      end
    end
  end

  // ---------------- stage 3: depth, focal products ----------------
  logic signed [DW-1:0] d_now;
  logic signed [DW-1:0] d3_q;
  logic signed [TW-1:0] tx_q, ty_q;
  side_t                sd_q [SDN];
  side_t                sd_new;
  logic signed [17:0]   f_s;

  assign d_now = -DW'(cam_q[2]);
  assign f_s   = $signed({2'b00, focal_q});

  always_comb begin
    sd_new.behind = d_now[DW-1] || (d_now == '0);
    if (sd_new.behind) begin
      sd_new.depth = '0;
    end else if (d_now > DW'({W{1'b1}})) begin
      sd_new.depth = '1;
    end else begin
      sd_new.depth = d_now[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q <= d_now;
      tx_q <= TW'(cam_q[0] * f_s);
      ty_q <= TW'(cam_q[1] * f_s);
    end
  end

  // ---------------- stage 4: projected numerators ----------------
  logic signed [NXW-1:0] nx_q, ny_q;
  logic [DENW-1:0]       den4_q, den5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= (NXW'(d3_q) <<< 8) + NXW'(tx_q);
      ny_q   <= (NXW'(d3_q) <<< 8) - NXW'(ty_q);
      den4_q <= DENW'(d3_q) << 9;
    end
  end

  // ---------------- stage 5: raster scale ----------------
  logic signed [NUMW-1:0] numx_q, numy_q;
  logic signed [13:0]     rxm1, rym1;

  assign rxm1 = $signed({1'b0, res_x_q}) - 14'sd1;
  assign rym1 = $signed({1'b0, res_y_q}) - 14'sd1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q <= NUMW'(nx_q * rxm1);
      numy_q <= NUMW'(ny_q * rym1);
      den5_q <= den4_q;
    end
  end

  // Sideband (flag and depth) follows its item from stage 3 to the end.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd_new;
      for (int s = 1; s < SDN; s++) begin
        sd_q[s] <= sd_q[s-1];
      end
    end
  end

  // ---------------- divide ----------------
  logic [W-1:0] qx, qy;
  logic         negx, negy, ovfx, ovfy;

  vtp_div #(.W(W), .NUM_W(NUMW), .DEN_W(DENW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numx_q),
    .den_i (den5_q),
    .q_o   (qx),
    .neg_o (negx),
    .ovf_o (ovfx)
  );

  vtp_div #(.W(W), .NUM_W(NUMW), .DEN_W(DENW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numy_q),
    .den_i (den5_q),
    .q_o   (qy),
    .neg_o (negy),
    .ovf_o (ovfy)
  );

  function automatic logic [W-1:0] sat_pix(input logic [W-1:0] q, input logic neg,
                                           input logic ovf);
    logic [W-1:0] res;
    if (!neg) begin
      res = (ovf || q[W-1]) ? PIX_HI : q;
    end else begin
      res = (ovf || (q > PIX_LO)) ? PIX_LO : W'(-q);
    end
    return res;
  endfunction

  // ---------------- output register ----------------
  logic [W-1:0] px_q, py_q, depth_q;
  logic         behind_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      behind_q <= sd_q[SDN-1].behind;
      depth_q  <= sd_q[SDN-1].depth;
      px_q     <= sd_q[SDN-1].behind ? '0 : sat_pix(qx, negx, ovfx);
      py_q     <= sd_q[SDN-1].behind ? '0 : sat_pix(qy, negy, ovfy);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDW'({depth_q, py_q, px_q});
  assign m_axis_tuser  = behind_q;

  // ---------------- assertions ----------------
  `VTP_ASSERT_NOW(a_behind_zero, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata == '0, "behind-camera item carries nonzero fields")
  `VTP_ASSERT_NOW(a_depth_nonzero, m_axis_tvalid && !m_axis_tuser,
    depth_q != '0, "visible item with zero view depth")
  `VTP_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled output item changed")
  `VTP_ASSERT_NEXT(a_pipe_frozen, !s_axis_tready,
    $stable(vld_q), "pipeline moved during a stall")

endmodule
`default_nettype wire
